### hdl/sha1s_pkg.sv
// Shared types and constants for the streaming SHA-1 hasher.
package sha1s_pkg;

    localparam int ROUNDS     = 80;
    localparam int WORDS      = 5;
    localparam int BLOCK_BITS = 512;

    localparam logic        CMD_ABSORB = 1'b0;
    localparam logic        CMD_FINISH = 1'b1;

    localparam logic [7:0]  PAD_BYTE   = 8'h80;
    localparam logic [7:0]  ZERO_BYTE  = 8'h00;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;
    localparam logic [5:0]  FILL_LAST  = 6'd63;
    localparam logic [2:0]  IDX_LAST   = 3'd4;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef logic [WORDS-1:0][31:0] t_chain;

    // Element 0 is H0.
    localparam t_chain IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                             32'hEFCDAB89, 32'h67452301};

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Sequencer to compression engine.
    typedef struct packed {
        logic       push;   // shift one byte into the block
        logic       go;     // block full after this byte: compress
        logic       init;   // reload chaining value with IV
        logic [7:0] data;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
    } t_core_sts;

endpackage

### hdl/sha1s_core.sv
// SHA-1 compression engine: block shift line, one round per cycle, chaining value.
module sha1s_core import sha1s_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_core_ctl i_ctl,
    output t_core_sts o_sts,
    output t_chain    o_h
);

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FOLD} t_state;

    localparam logic [6:0] RND_LAST = 7'(ROUNDS - 1);

    t_state                  r_state;
    logic [6:0]              r_rnd;
    logic [BLOCK_BITS-1:0]   r_blk;   // word 0 sits at the top
    logic [31:0]             r_a, r_b, r_c, r_d, r_e;
    t_chain                  r_h;

    logic [31:0] w0, w2, w8, w13, w_mix, w_new, f, k, t;

    assign w0  = r_blk[BLOCK_BITS-1      -: 32];
    assign w2  = r_blk[BLOCK_BITS-1-64   -: 32];
    assign w8  = r_blk[BLOCK_BITS-1-256  -: 32];
    assign w13 = r_blk[BLOCK_BITS-1-416  -: 32];

    // Window of 16 words slides by one each round; the schedule word
    // for round i+16 enters at the bottom.
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb begin
        priority if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
    end

    assign t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_h     <= IV;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_ctl.init) begin
                        r_h <= IV;
                    end
                    if (i_ctl.push) begin
                        r_blk <= {r_blk[BLOCK_BITS-9:0], i_ctl.data};
                        if (i_ctl.go) begin
                            r_a     <= r_h[0];
                            r_b     <= r_h[1];
                            r_c     <= r_h[2];
                            r_d     <= r_h[3];
                            r_e     <= r_h[4];
                            r_rnd   <= '0;
                            r_state <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    r_blk <= {r_blk[BLOCK_BITS-33:0], w_new};
                    r_e   <= r_d;
                    r_d   <= r_c;
                    r_c   <= {r_b[1:0], r_b[31:2]};
                    r_b   <= r_a;
                    r_a   <= t;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == RND_LAST) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_h        = r_h;

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> r_state == ST_IDLE)
        else $error("byte pushed while compressing");

    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == RND_LAST) |=> r_state == ST_FOLD)
        else $error("round 79 not followed by fold");

    a_init_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.init |-> (r_state == ST_IDLE && !i_ctl.push))
        else $error("chaining reload during activity");

endmodule

### hdl/sha1_stream_hasher.sv
// Top level of the streaming SHA-1 hasher: byte intake, padding sequencer, digest output.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one transfer per
// command. Absorb places one byte in the block; finish pads the message
// and produces the digest. Output channel (o_out_valid / i_out_stall /
// o_out_data): five transfers per finish, H0 first, the fifth marked by
// last_word.
// An absorb that does not fill a block leaves the input open. The byte that
// fills a 64-byte block holds the input stalled while the shared round unit
// of sha1s_core runs the 80 rounds, folds the result into the chaining value
// and hands back, so no byte is taken while a block is being compressed.
// A finish pushes pad bytes (9 to 72) one per cycle while the core is idle,
// through the same block path, and runs one or two compressions, then
// offers the five digest words on consecutive cycles while i_out_stall is
// low. A stalled word holds steady. The input stays stalled until the last
// word's transfer, after which the chaining value, fill and byte count
// return to their initial values and a new message may start.
// Reset (synchronous, active low) loads the standard initial hash and
// clears the fill and the byte count; the block buffer is not cleared.
module sha1_stream_hasher import sha1s_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_COMP, ST_PAD, ST_FINWAIT, ST_OUT} t_state;

    t_state      r_state;
    logic [5:0]  r_fill;      // bytes in the current block
    logic [60:0] r_count;     // message bytes, wraps at 2^61
    logic        r_first;     // next pad byte is the 0x80 marker
    logic        r_inlen;     // inside the length field
    logic [63:0] r_len_sr;    // bit length, sent MSB byte first
    logic [2:0]  r_widx;

    t_core_ctl   core_ctl;
    t_core_sts   core_sts;
    t_chain      core_h;

    logic in_xfer, out_xfer, len_phase;

    sha1s_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_sts   (core_sts),
        .o_h     (core_h)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;

    // Length bytes start once the fill reaches offset 56 after the marker.
    assign len_phase = !r_first && (r_inlen || r_fill == LEN_OFFSET);

    always_comb begin
        core_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && i_in_data.command == CMD_ABSORB) begin
                    core_ctl.push = 1'b1;
                    core_ctl.data = i_in_data.data_byte;
                    core_ctl.go   = (r_fill == FILL_LAST);
                end
            end
            ST_PAD: begin
                if (!core_sts.busy) begin
                    core_ctl.push = 1'b1;
                    core_ctl.go   = (r_fill == FILL_LAST);
                    priority if (r_first) begin
                        core_ctl.data = PAD_BYTE;
                    end else if (len_phase) begin
                        core_ctl.data = r_len_sr[63:56];
                    end else begin
                        core_ctl.data = ZERO_BYTE;
                    end
                end
            end
            ST_OUT: begin
                core_ctl.init = out_xfer && (r_widx == IDX_LAST);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_count <= '0;
            r_first <= 1'b0;
            r_inlen <= 1'b0;
            r_widx  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.command == CMD_ABSORB) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + 61'd1;
                            if (r_fill == FILL_LAST) begin
                                r_state <= ST_COMP;
                            end
                        end else begin
                            r_len_sr <= {r_count, 3'b000};
                            r_first  <= 1'b1;
                            r_inlen  <= 1'b0;
                            r_state  <= ST_PAD;
                        end
                    end
                end
                ST_COMP: begin
                    if (!core_sts.busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    if (!core_sts.busy) begin
                        r_fill  <= r_fill + 6'd1;
                        r_first <= 1'b0;
                        if (len_phase) begin
                            r_inlen  <= 1'b1;
                            r_len_sr <= {r_len_sr[55:0], ZERO_BYTE};
                            if (r_fill == FILL_LAST) begin
                                r_inlen <= 1'b0;
                                r_state <= ST_FINWAIT;
                            end
                        end
                    end
                end
                ST_FINWAIT: begin
                    if (!core_sts.busy) begin
                        r_widx  <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        if (r_widx == IDX_LAST) begin
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (r_widx)
            3'd0:    o_out_data.digest_word = core_h[0];
            3'd1:    o_out_data.digest_word = core_h[1];
            3'd2:    o_out_data.digest_word = core_h[2];
            3'd3:    o_out_data.digest_word = core_h[3];
            default: o_out_data.digest_word = core_h[4];
        endcase
    end

    assign o_out_data.word_index = r_widx;
    assign o_out_data.last_word  = (r_widx == IDX_LAST);

    a_out_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while digest pending");

    a_len_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inlen |-> (r_fill >= LEN_OFFSET && !r_first))
        else $error("length field outside offsets 56 to 63");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_widx == IDX_LAST) |=> (!o_out_valid && r_fill == '0
                                              && r_count == '0))
        else $error("state not back to initial after digest");

endmodule

### test/sha1_digest_checker.sv
// Digest checker for the streaming SHA-1 hasher: tracks transfers, predicts and compares.
module sha1_digest_checker import sha1s_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending,
    output int   o_words_checked
);

    t_chain      hash_state;
    logic [7:0]  msg_block [64];
    logic [5:0]  block_fill;
    logic [60:0] byte_total;
    t_out        digest_queue [$];
    int          error_count;
    int          word_count;

    initial begin
        o_errors        = 0;
        o_pending       = 0;
        o_words_checked = 0;
        error_count     = 0;
        word_count      = 0;
    end

    function automatic void restart_message();
        hash_state = IV;
        block_fill = '0;
        byte_total = '0;
    endfunction

    // 80 rounds over the current block, folded into the chaining value.
    function automatic void fold_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < ROUNDS; i++) begin
            t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int i = 0; i < ROUNDS; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    function automatic void take_byte(logic [7:0] value);
        msg_block[block_fill] = value;
        block_fill = block_fill + 6'd1;
        if (block_fill == '0)
            fold_block();
    endfunction

    // Pad, fold the tail and queue the five digest words.
    function automatic void close_message();
        logic [63:0] bit_len;
        t_out        word;
        bit_len = {byte_total, 3'b000};
        take_byte(PAD_BYTE);
        while (block_fill != LEN_OFFSET)
            take_byte(ZERO_BYTE);
        for (int i = 7; i >= 0; i--)
            take_byte(bit_len[8*i +: 8]);
        for (int i = 0; i < WORDS; i++) begin
            word.digest_word = hash_state[i];
            word.word_index  = 3'(i);
            word.last_word   = (word.word_index == IDX_LAST);
            digest_queue.push_back(word);
        end
        restart_message();
    endfunction

    function automatic void check_word(t_out got);
        t_out want;
        if (digest_queue.size() == 0) begin
            $error("digest word %h (index %0d) with no digest outstanding",
                   got.digest_word, got.word_index);
            error_count++;
        end else begin
            want = digest_queue.pop_front();
            word_count++;
            if (got.digest_word !== want.digest_word) begin
                $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
                error_count++;
            end
            if (got.word_index !== want.word_index) begin
                $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
                error_count++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
                error_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_message();
            digest_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_word(i_out_data);
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.command == CMD_ABSORB) begin
                    take_byte(i_in_data.data_byte);
                    byte_total = byte_total + 61'd1;
                end else begin
                    close_message();
                end
            end
        end
        o_errors        <= error_count;
        o_pending       <= digest_queue.size();
        o_words_checked <= word_count;
    end

endmodule

### test/testbench.sv
// Testbench top for the streaming SHA-1 hasher: stimulus, idling and verdict.
module testbench;
    import sha1s_pkg::*;

    // Worst case per item: a long sender gap, a full compression, a two-block
    // padding pass and five digest words each behind a long receiver stall.
    // The whole run is expected to stay well under this limit.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 150;
    localparam int MIN_MESSAGES = 8;
    // Let a trailing compression finish before the verdict.
    localparam int TAIL_CYCLES  = 200;

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic out_stall = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    int   error_total;
    int   pending_words;
    int   words_checked;
    int   cycle_count   = 0;
    int   items_sent    = 0;
    int   messages_sent = 0;
    int   bytes_sent    = 0;
    // Set per message: no idling on either side while high.
    bit   quiet_run     = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sha1_stream_hasher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sha1_digest_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_data       (in_data),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_data      (out_data),
        .o_errors        (error_total),
        .o_pending       (pending_words),
        .o_words_checked (words_checked)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Receiver side: random stall bursts, dropped at the falling edge.
    // Each step ends by clearing out_stall.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet_run && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (pick_gap()) @(negedge i_clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** sha1_stream_hasher: FAILED **");
            $finish;
        end
    end

    // One input transfer. Optional idle gap first, with junk on the bus
    // while valid is low; the payload is then held until accepted.
    task automatic offer(input logic cmd, input logic [7:0] value);
        int gap;
        gap = (quiet_run || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid          <= 1'b0;
            in_data.command   <= 1'($urandom);
            in_data.data_byte <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, data_byte: value};
        do @(posedge i_clk); while (in_stall);
        items_sent++;
    endtask

    // Random-content message of the given length, then the finish.
    task automatic send_message(input int length, input logic [7:0] finish_data);
        for (int n = 0; n < length; n++)
            offer(CMD_ABSORB, 8'($urandom));
        offer(CMD_FINISH, finish_data);
        messages_sent++;
        bytes_sent += length;
    endtask

    // Hold the sender until every predicted digest word has been seen.
    // Valid drops first so the last transfer is not taken again; the
    // following edge lets the checker's count catch up with it.
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    initial begin
        int          length;
        int          random_messages;
        int          boundary [5];
        logic [7:0]  corner [4];

        // Message lengths either side of the one/two padding-block split,
        // a whole block, and a two-block message with a wider length field.
        boundary = '{55, 56, 63, 64, 120};
        corner   = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        random_messages = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed: empty message with data on the finish (ignored),
        // then "abc", then the byte extremes, then an empty message
        // straight after a digest.
        quiet_run = 1'b1;
        send_message(0, 8'hFF);
        offer(CMD_ABSORB, 8'h61);
        offer(CMD_ABSORB, 8'h62);
        offer(CMD_ABSORB, 8'h63);
        offer(CMD_FINISH, 8'h00);
        messages_sent++;
        bytes_sent += 3;
        quiet_run = 1'b0;
        foreach (corner[i])
            offer(CMD_ABSORB, corner[i]);
        offer(CMD_FINISH, 8'hA5);
        messages_sent++;
        bytes_sent += 4;
        send_message(0, 8'h5A);
        drain();

        // Random: mostly short messages, a quarter at the padding boundaries.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS || random_messages < MIN_MESSAGES) begin
            quiet_run = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                length = boundary[$urandom_range(0, 4)];
            else
                length = $urandom_range(0, 12);
            send_message(length, 8'($urandom));
            random_messages++;
            if (random_messages == 3)
                drain();
        end
        quiet_run = 1'b0;

        @(negedge i_clk);
        in_valid <= 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages (%0d bytes, empty and boundary lengths included);",
                 messages_sent, bytes_sent);
        $display("%0d digest words compared under random gaps and output stalls.",
                 words_checked);
        if (error_total == 0)
            $display("** sha1_stream_hasher: PASSED **");
        else
            $display("** sha1_stream_hasher: FAILED **");
        $finish;
    end

endmodule

### sim.f
hdl/sha1s_pkg.sv
hdl/sha1s_core.sv
hdl/sha1_stream_hasher.sv
test/sha1_digest_checker.sv
test/testbench.sv
